// ===== hdl/nearest_hit_pair_search_unit_defines.svh =====
// Assertion macros for the nearest hit pair search unit.
`ifndef NEAREST_HIT_PAIR_SEARCH_UNIT_DEFINES_SVH
`define NEAREST_HIT_PAIR_SEARCH_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NHPS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("nearest hit pair search: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define NHPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("nearest hit pair search: next-cycle check failed");

`endif

// ===== hdl/nhps_pkg.sv =====
package nhps_pkg;

  localparam int unsigned COORD_WIDTH = 32;
  localparam int unsigned CFG_WIDTH   = 31;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned STEP_W      = $clog2(COORD_WIDTH);

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(COORD_WIDTH - 1);

  localparam logic [CFG_WIDTH-1:0] CUTOFF_RESET  = CFG_WIDTH'(2147483647);
  localparam logic [CFG_WIDTH-1:0] MODULUS_RESET = CFG_WIDTH'(65536);

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_HIT   = 2'd1,
    CMD_END   = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AXIS    = 2'd0,
    CFG_CUTOFF  = 2'd1,
    CFG_MODULUS = 2'd2
  } cfg_idx_e;

  localparam logic [1:0] PLANE_DIFF = 2'd0;
  localparam logic [1:0] PLANE_ONE  = 2'd1;
  localparam logic [1:0] PLANE_TWO  = 2'd2;

  typedef struct packed {
    logic                   start;
    logic [COORD_WIDTH-1:0] dividend;
    logic [CFG_WIDTH-1:0]   divisor;
  } mod_req_t;

  typedef struct packed {
    logic                   busy;
    logic                   done;
    logic [COORD_WIDTH-1:0] remainder;
  } mod_rsp_t;

endpackage

// ===== hdl/nhps_if.sv =====
interface nhps_pair_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      cmd;
  logic [nhps_pkg::COORD_WIDTH-1:0] first_x;
  logic [nhps_pkg::COORD_WIDTH-1:0] first_y;
  logic [nhps_pkg::COORD_WIDTH-1:0] second_x;
  logic [nhps_pkg::COORD_WIDTH-1:0] second_y;

  modport source (output valid, cmd, first_x, first_y, second_x, second_y, input ready);
  modport sink (input valid, cmd, first_x, first_y, second_x, second_y, output ready);
endinterface

interface nhps_result_if;
  logic                            valid;
  logic                            ready;
  logic [nhps_pkg::COORD_WIDTH-1:0] out_x;
  logic [nhps_pkg::COORD_WIDTH-1:0] out_y;
  logic [1:0]                      plane_id;
  logic                            last;

  modport source (output valid, out_x, out_y, plane_id, last, input ready);
  modport sink (input valid, out_x, out_y, plane_id, last, output ready);
endinterface

// ===== hdl/nhps_mod_unit.sv =====
module nhps_mod_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  nhps_pkg::mod_req_t req_i,
  output nhps_pkg::mod_rsp_t rsp_o
);

  logic                               busy_q;
  logic                               done_q;
  logic [nhps_pkg::STEP_W-1:0]        cnt_q;
  logic                               neg_q;
  logic [nhps_pkg::COORD_WIDTH-1:0]   mag_q;
  logic [nhps_pkg::COORD_WIDTH-1:0]   rem_q;
  logic [nhps_pkg::CFG_WIDTH-1:0]     div_q;
  logic [nhps_pkg::COORD_WIDTH-1:0]   res_q;
  logic [nhps_pkg::COORD_WIDTH:0]     trial;
  logic [nhps_pkg::COORD_WIDTH:0]     div_ext;
  logic [nhps_pkg::COORD_WIDTH:0]     rem_step;
  logic [nhps_pkg::COORD_WIDTH-1:0]   rem_d;

  // Restoring remainder, one dividend bit per cycle. A zero divisor always
  // fits, so the remainder then ends equal to the magnitude itself.
  always_comb begin
    trial    = {rem_q, mag_q[nhps_pkg::COORD_WIDTH-1]};
    div_ext  = {2'b00, div_q};
    rem_step = (trial >= div_ext) ? (trial - div_ext) : trial;
    rem_d    = rem_step[nhps_pkg::COORD_WIDTH-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == nhps_pkg::STEP_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.dividend[nhps_pkg::COORD_WIDTH-1];
      mag_q <= req_i.dividend[nhps_pkg::COORD_WIDTH-1] ? ('0 - req_i.dividend) : req_i.dividend;
      rem_q <= '0;
      div_q <= req_i.divisor;
    end else if (busy_q) begin
      mag_q <= {mag_q[nhps_pkg::COORD_WIDTH-2:0], 1'b0};
      rem_q <= rem_d;
      if (cnt_q == nhps_pkg::STEP_LAST) begin
        res_q <= neg_q ? ('0 - rem_d) : rem_d;
      end
    end
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.remainder = res_q;

endmodule

// ===== hdl/nearest_hit_pair_search_unit.sv =====
// Nearest hit pair search unit.
// The pair_i channel carries one item per beat: an event start, a hit pair or an
// event end, with both hits in signed Q16.16. The result_o channel carries the
// winning pair of an event as three beats: the difference vector, then hit one
// and hit two with the searched coordinate folded by the modulus; the third beat
// has last set. The cfg port writes axis_select, cutoff_distance and modulus.
// Event start and hit pair beats are taken while the unit is idle; an event end
// without a winner loads no result beat. An event end with a winner puts the
// difference beat on result_o in the next cycle, and each folded hit is loaded
// from S_PUT_ONE or S_PUT_TWO after the shared remainder unit finishes it.
// The input is not ready while the folds run. After the last beat is loaded, the
// unit takes hit pairs again even while that beat waits.
// A stall on result_o holds the output register and the sequencer; an event end
// is not taken while a result is still waiting. Reset clears the configuration to
// axis x, cutoff 2147483647 and modulus 65536, and the running best to the cutoff.
`include "nearest_hit_pair_search_unit_defines.svh"

module nearest_hit_pair_search_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [nhps_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [nhps_pkg::CFG_WIDTH-1:0]    cfg_data_i,
  nhps_pair_if.sink                         pair_i,
  nhps_result_if.source                     result_o
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_FOLD_ONE = 5'b00010,
    S_PUT_ONE  = 5'b00100,
    S_FOLD_TWO = 5'b01000,
    S_PUT_TWO  = 5'b10000
  } state_e;

  localparam int unsigned W = nhps_pkg::COORD_WIDTH;

  state_e state_q, state_d;

  logic                          axis_q;
  logic [nhps_pkg::CFG_WIDTH-1:0] cutoff_q;
  logic [nhps_pkg::CFG_WIDTH-1:0] modulus_q;

  logic [W-1:0] best_q;
  logic [W-1:0] diff_x_q, diff_y_q;
  logic [W-1:0] one_x_q, one_y_q;
  logic [W-1:0] two_x_q, two_y_q;

  logic         out_valid_q, out_valid_d;
  logic [W-1:0] out_x_q, out_y_q, out_x_d, out_y_d;
  logic [1:0]   out_plane_q, out_plane_d;
  logic         out_last_q, out_last_d;
  logic         out_load;
  logic         out_free;

  logic [W:0]   dx, dy;
  logic [W:0]   dx_neg, dy_neg;
  logic [W-1:0] dist_x, dist_y, cand;
  logic [W-1:0] sat_x, sat_y;
  logic         take;
  logic         winner;

  logic               accept;
  nhps_pkg::cmd_e     cmd;
  nhps_pkg::mod_req_t mod_req;
  nhps_pkg::mod_rsp_t mod_rsp;

  nhps_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q    <= 1'b0;
      cutoff_q  <= nhps_pkg::CUTOFF_RESET;
      modulus_q <= nhps_pkg::MODULUS_RESET;
    end else if (cfg_we_i) begin
      case (nhps_pkg::cfg_idx_e'(cfg_idx_i))
        nhps_pkg::CFG_AXIS:    axis_q    <= cfg_data_i[0];
        nhps_pkg::CFG_CUTOFF:  cutoff_q  <= cfg_data_i;
        nhps_pkg::CFG_MODULUS: modulus_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Differences are taken one bit wider so that the distance stays exact.
  always_comb begin
    dx     = {pair_i.first_x[W-1], pair_i.first_x} - {pair_i.second_x[W-1], pair_i.second_x};
    dy     = {pair_i.first_y[W-1], pair_i.first_y} - {pair_i.second_y[W-1], pair_i.second_y};
    dx_neg = '0 - dx;
    dy_neg = '0 - dy;
    dist_x = dx[W] ? dx_neg[W-1:0] : dx[W-1:0];
    dist_y = dy[W] ? dy_neg[W-1:0] : dy[W-1:0];

    if (!dx[W] && dx[W-1]) begin
      sat_x = {1'b0, {(W-1){1'b1}}};
    end else if (dx[W] && !dx[W-1]) begin
      sat_x = {1'b1, {(W-1){1'b0}}};
    end else begin
      sat_x = dx[W-1:0];
    end
    if (!dy[W] && dy[W-1]) begin
      sat_y = {1'b0, {(W-1){1'b1}}};
    end else if (dy[W] && !dy[W-1]) begin
      sat_y = {1'b1, {(W-1){1'b0}}};
    end else begin
      sat_y = dy[W-1:0];
    end

    cand   = axis_q ? dist_y : dist_x;
    take   = (cand != '0) && (cand < best_q);
    winner = best_q < {1'b0, cutoff_q};
  end

  assign cmd          = nhps_pkg::cmd_e'(pair_i.cmd);
  assign out_free     = !out_valid_q || result_o.ready;
  assign pair_i.ready = (state_q == S_IDLE) && ((cmd != nhps_pkg::CMD_END) || out_free);
  assign accept       = pair_i.valid && pair_i.ready;

  always_comb begin
    state_d          = state_q;
    mod_req.start    = 1'b0;
    mod_req.dividend = axis_q ? one_y_q : one_x_q;
    mod_req.divisor  = modulus_q;
    out_load         = 1'b0;
    out_x_d          = diff_x_q;
    out_y_d          = diff_y_q;
    out_plane_d      = nhps_pkg::PLANE_DIFF;
    out_last_d       = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept && (cmd == nhps_pkg::CMD_END) && winner) begin
          out_load      = 1'b1;
          mod_req.start = 1'b1;
          state_d       = S_FOLD_ONE;
        end
      end
      S_FOLD_ONE: begin
        if (mod_rsp.done) begin
          state_d = S_PUT_ONE;
        end
      end
      S_PUT_ONE: begin
        out_x_d     = axis_q ? one_x_q : mod_rsp.remainder;
        out_y_d     = axis_q ? mod_rsp.remainder : one_y_q;
        out_plane_d = nhps_pkg::PLANE_ONE;
        if (out_free) begin
          out_load         = 1'b1;
          mod_req.start    = 1'b1;
          mod_req.dividend = axis_q ? two_y_q : two_x_q;
          state_d          = S_FOLD_TWO;
        end
      end
      S_FOLD_TWO: begin
        if (mod_rsp.done) begin
          state_d = S_PUT_TWO;
        end
      end
      S_PUT_TWO: begin
        out_x_d     = axis_q ? two_x_q : mod_rsp.remainder;
        out_y_d     = axis_q ? mod_rsp.remainder : two_y_q;
        out_plane_d = nhps_pkg::PLANE_TWO;
        out_last_d  = 1'b1;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_valid_d = out_load ? 1'b1 : (result_o.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      best_q      <= {1'b0, nhps_pkg::CUTOFF_RESET};
      diff_x_q    <= '0;
      diff_y_q    <= '0;
      one_x_q     <= '0;
      one_y_q     <= '0;
      two_x_q     <= '0;
      two_y_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        case (cmd)
          nhps_pkg::CMD_START: begin
            best_q   <= {1'b0, cutoff_q};
            diff_x_q <= '0;
            diff_y_q <= '0;
            one_x_q  <= '0;
            one_y_q  <= '0;
            two_x_q  <= '0;
            two_y_q  <= '0;
          end
          nhps_pkg::CMD_HIT: begin
            if (take) begin
              best_q   <= cand;
              diff_x_q <= sat_x;
              diff_y_q <= sat_y;
              one_x_q  <= pair_i.first_x;
              one_y_q  <= pair_i.first_y;
              two_x_q  <= pair_i.second_x;
              two_y_q  <= pair_i.second_y;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_x_q     <= out_x_d;
      out_y_q     <= out_y_d;
      out_plane_q <= out_plane_d;
      out_last_q  <= out_last_d;
    end
  end

  assign result_o.valid    = out_valid_q;
  assign result_o.out_x    = out_x_q;
  assign result_o.out_y    = out_y_q;
  assign result_o.plane_id = out_plane_q;
  assign result_o.last     = out_last_q;

  `NHPS_ASSERT_SAME(a_ready_only_idle, clk_i, rst_ni, pair_i.ready, state_q == S_IDLE)
  `NHPS_ASSERT_SAME(a_start_when_free, clk_i, rst_ni, mod_req.start, !mod_rsp.busy)
  `NHPS_ASSERT_NEXT(a_last_after_two, clk_i, rst_ni, out_load && out_last_d, result_o.valid && result_o.last && (result_o.plane_id == nhps_pkg::PLANE_TWO))

endmodule

// ===== dv/nearest_hit_pair_search_unit_test.sv =====
`timescale 1ns / 100ps

module nearest_hit_pair_search_unit_test;

  localparam int unsigned COORD_WIDTH = nhps_pkg::COORD_WIDTH;
  localparam int unsigned CFG_WIDTH   = nhps_pkg::CFG_WIDTH;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [CFG_WIDTH-1:0] REG_MAX = 31'h7fff_ffff;
  localparam logic signed [COORD_WIDTH:0] SAT_HI = 33'sd2147483647;
  localparam logic signed [COORD_WIDTH:0] SAT_LO = -33'sd2147483648;
  localparam int IDLE_WAIT = 80;
  localparam int RANDOM_ITEMS = 170;

  typedef logic [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    logic [1:0] cmd;
    coord_t     ax;
    coord_t     ay;
    coord_t     bx;
    coord_t     by;
  } pair_item_t;

  typedef struct packed {
    coord_t     x;
    coord_t     y;
    logic [1:0] plane;
    logic       last;
  } point_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we;
  nhps_pkg::cfg_idx_e   cfg_idx;
  logic [CFG_WIDTH-1:0] cfg_data;

  nhps_pair_if   pair_bus ();
  nhps_result_if result_bus ();

  nearest_hit_pair_search_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pair_i     (pair_bus),
    .result_o   (result_bus)
  );

  always #2 clk_i = ~clk_i;

  // Search state and register copies, kept in step with accepted beats.
  logic                 axis_y;
  logic [CFG_WIDTH-1:0] cut_lim;
  logic [CFG_WIDTH-1:0] fold_mod;
  coord_t near_best, keep_dx, keep_dy, keep_ax, keep_ay, keep_bx, keep_by;

  point_t pending_points[$];
  int     errors = 0;
  int     items_sent = 0;
  int     burst_left = 0;
  bit     pair_held = 1'b0;
  int     rx_mode = 0;
  int     rx_span = 0;

  function automatic void measure(input coord_t a, input coord_t b,
                                  output coord_t gap_len, output coord_t clamped);
    logic signed [COORD_WIDTH:0] d;
    d = $signed({a[COORD_WIDTH-1], a}) - $signed({b[COORD_WIDTH-1], b});
    gap_len = d[COORD_WIDTH] ? COORD_WIDTH'(-d) : d[COORD_WIDTH-1:0];
    if (d > SAT_HI) begin
      clamped = 32'h7fff_ffff;
    end else if (d < SAT_LO) begin
      clamped = 32'h8000_0000;
    end else begin
      clamped = d[COORD_WIDTH-1:0];
    end
  endfunction

  function automatic coord_t fold_coord(input coord_t v);
    coord_t mag, rem;
    if (fold_mod == '0) return v;
    mag = v[COORD_WIDTH-1] ? -v : v;
    rem = mag % {1'b0, fold_mod};
    return v[COORD_WIDTH-1] ? -rem : rem;
  endfunction

  function automatic void track_item(input pair_item_t it);
    coord_t dx, dy, cx, cy, cand;
    point_t p;
    case (it.cmd)
      nhps_pkg::CMD_START: begin
        near_best = {1'b0, cut_lim};
        keep_dx = '0;
        keep_dy = '0;
        keep_ax = '0;
        keep_ay = '0;
        keep_bx = '0;
        keep_by = '0;
      end
      nhps_pkg::CMD_HIT: begin
        measure(it.ax, it.bx, dx, cx);
        measure(it.ay, it.by, dy, cy);
        cand = axis_y ? dy : dx;
        if (cand != '0 && cand < near_best) begin
          near_best = cand;
          keep_dx = cx;
          keep_dy = cy;
          keep_ax = it.ax;
          keep_ay = it.ay;
          keep_bx = it.bx;
          keep_by = it.by;
        end
      end
      nhps_pkg::CMD_END: begin
        if (near_best < {1'b0, cut_lim}) begin
          p = '{x: keep_dx, y: keep_dy, plane: nhps_pkg::PLANE_DIFF, last: 1'b0};
          pending_points = {pending_points, p};
          p.x = axis_y ? keep_ax : fold_coord(keep_ax);
          p.y = axis_y ? fold_coord(keep_ay) : keep_ay;
          p.plane = nhps_pkg::PLANE_ONE;
          pending_points = {pending_points, p};
          p.x = axis_y ? keep_bx : fold_coord(keep_bx);
          p.y = axis_y ? fold_coord(keep_by) : keep_by;
          p.plane = nhps_pkg::PLANE_TWO;
          p.last = 1'b1;
          pending_points = {pending_points, p};
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic pair_item_t make_item(input logic [1:0] cmd, input coord_t ax,
                                           input coord_t ay, input coord_t bx,
                                           input coord_t by);
    pair_item_t it;
    it = '{cmd: cmd, ax: ax, ay: ay, bx: bx, by: by};
    return it;
  endfunction

  function automatic coord_t near_coord(input coord_t base, input int unsigned spread);
    return base + coord_t'($urandom_range(0, 2 * spread)) - coord_t'(spread);
  endfunction

  function automatic void compare_field(input string name, input coord_t want,
                                        input coord_t seen);
    if (want !== seen) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, seen);
    end
  endfunction

  task automatic send_item(input pair_item_t it);
    pair_bus.valid    <= 1'b1;
    pair_bus.cmd      <= it.cmd;
    pair_bus.first_x  <= it.ax;
    pair_bus.first_y  <= it.ay;
    pair_bus.second_x <= it.bx;
    pair_bus.second_y <= it.by;
    do @(posedge clk_i); while (!pair_bus.ready);
    track_item(it);
    items_sent++;
    pair_held = 1'b1;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      pair_bus.valid <= 1'b0;
      pair_held = 1'b0;
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(20, 80)) @(posedge clk_i);
      end else begin
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic settle();
    if (pair_held) begin
      pair_bus.valid <= 1'b0;
      pair_held = 1'b0;
    end
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (IDLE_WAIT) @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic axis, input logic [CFG_WIDTH-1:0] cutoff,
                                input logic [CFG_WIDTH-1:0] period);
    settle();
    cfg_we   <= 1'b1;
    cfg_idx  <= nhps_pkg::CFG_AXIS;
    cfg_data <= CFG_WIDTH'(axis);
    @(posedge clk_i);
    axis_y = axis;
    cfg_idx  <= nhps_pkg::CFG_CUTOFF;
    cfg_data <= cutoff;
    @(posedge clk_i);
    cut_lim = cutoff;
    cfg_idx  <= nhps_pkg::CFG_MODULUS;
    cfg_data <= period;
    @(posedge clk_i);
    fold_mod = period;
    cfg_we <= 1'b0;
  endtask

  // Runs on reset settings, leaves out the first event's start and sends an unused command.
  task automatic test_missing_start();
    send_item(make_item(nhps_pkg::CMD_HIT, 32'h8000_0000, 32'h1234_5678, 32'h7fff_ffff,
                        32'hedcb_a987));
    send_item(make_item(nhps_pkg::CMD_HIT, 32'h0005_0000, 32'h1, 32'h0005_0000, 32'h2));
    send_item(make_item(CMD_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                        32'hffff_ffff));
    send_item(make_item(nhps_pkg::CMD_HIT, 32'h0003_8000, 32'hfffe_0000, 32'hfffd_4000,
                        32'h0002_0000));
    send_item(make_item(nhps_pkg::CMD_END, '0, '0, '0, '0));
    send_item(make_item(nhps_pkg::CMD_START, '0, '0, '0, '0));
    send_item(make_item(nhps_pkg::CMD_END, '0, '0, '0, '0));
  endtask

  task automatic test_fold_on_y();
    apply_settings(1'b1, 31'h0010_0000, 31'h0002_8000);
    send_item(make_item(nhps_pkg::CMD_START, '0, '0, '0, '0));
    send_item(make_item(nhps_pkg::CMD_HIT, 32'h1111_1111, 32'hfff9_0000, 32'h2222_2222,
                        32'hfffa_0000));
    send_item(make_item(nhps_pkg::CMD_HIT, 32'h7fff_ffff, 32'h0005_3000, 32'h8000_0000,
                        32'h0005_b000));
    send_item(make_item(nhps_pkg::CMD_END, '0, '0, '0, '0));
  endtask

  task automatic test_saturation();
    apply_settings(1'b1, REG_MAX, 31'd1);
    send_item(make_item(nhps_pkg::CMD_START, '0, '0, '0, '0));
    send_item(make_item(nhps_pkg::CMD_HIT, 32'h7fff_ffff, 32'h1, 32'h8000_0000, 32'h3));
    send_item(make_item(nhps_pkg::CMD_END, '0, '0, '0, '0));
    apply_settings(1'b1, REG_MAX, REG_MAX);
    send_item(make_item(nhps_pkg::CMD_START, '0, '0, '0, '0));
    send_item(make_item(nhps_pkg::CMD_HIT, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                        32'h7fff_fffe));
    send_item(make_item(nhps_pkg::CMD_END, '0, '0, '0, '0));
  endtask

  task automatic test_cutoff_bounds();
    apply_settings(1'b0, '0, REG_MAX);
    send_item(make_item(nhps_pkg::CMD_START, '0, '0, '0, '0));
    send_item(make_item(nhps_pkg::CMD_HIT, 32'h1, '0, 32'h2, '0));
    send_item(make_item(nhps_pkg::CMD_END, '0, '0, '0, '0));
    apply_settings(1'b0, 31'd2, REG_MAX);
    send_item(make_item(nhps_pkg::CMD_START, '0, '0, '0, '0));
    send_item(make_item(nhps_pkg::CMD_HIT, 32'h8000_0000, 32'h5, 32'h8000_0001, 32'h6));
    send_item(make_item(nhps_pkg::CMD_END, '0, '0, '0, '0));
  endtask

  task automatic test_random_events();
    int first, kind, hits;
    int unsigned spread;
    logic [CFG_WIDTH-1:0] cutoff, period;
    coord_t base_x, base_y, ax, ay, bx, by;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0: cutoff = REG_MAX;
        1: cutoff = CFG_WIDTH'($urandom_range(1, 1 << 26));
        2: cutoff = CFG_WIDTH'($urandom_range(1, 1 << 20));
        3: cutoff = CFG_WIDTH'($urandom() >> 1);
        4: cutoff = CFG_WIDTH'($urandom_range(0, 2));
        default: cutoff = CFG_WIDTH'($urandom_range(1 << 16, 1 << 24));
      endcase
      case ($urandom_range(0, 4))
        0: period = 31'd1;
        1: period = REG_MAX;
        2: period = nhps_pkg::MODULUS_RESET;
        3: period = CFG_WIDTH'($urandom_range(1, 1 << 22));
        default: period = CFG_WIDTH'($urandom() >> 1) | 31'd1;
      endcase
      apply_settings(1'($urandom_range(0, 1)), cutoff, period);
      repeat ($urandom_range(3, 8)) begin
        kind = $urandom_range(0, 9);
        hits = $urandom_range(1, 6);
        spread = 1 << $urandom_range(2, 24);
        base_x = $urandom();
        base_y = $urandom();
        if (kind == 8) begin
          repeat ($urandom_range(1, 3)) begin
            send_item(make_item(2'($urandom_range(0, 3)), $urandom(), $urandom(),
                                $urandom(), $urandom()));
          end
        end else begin
          if (kind != 7) send_item(make_item(nhps_pkg::CMD_START, $urandom(), $urandom(),
                                             $urandom(), $urandom()));
          repeat (hits) begin
            if ($urandom_range(0, 9) == 0) begin
              ax = $urandom();
              ay = $urandom();
              bx = $urandom();
              by = $urandom();
            end else begin
              ax = near_coord(base_x, spread);
              ay = near_coord(base_y, spread);
              bx = near_coord(base_x, spread);
              by = near_coord(base_y, spread);
            end
            if ($urandom_range(0, 15) == 0) begin
              bx = ax;
              by = ay;
            end
            send_item(make_item(nhps_pkg::CMD_HIT, ax, ay, bx, by));
          end
          if (kind != 9) send_item(make_item(nhps_pkg::CMD_END, $urandom(), $urandom(),
                                             $urandom(), $urandom()));
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rx_span == 0) begin
      rx_mode <= $urandom_range(0, 2);
      rx_span <= $urandom_range(50, 300);
    end else begin
      rx_span <= rx_span - 1;
    end
    case (rx_mode)
      0: result_bus.ready <= 1'b1;
      1: result_bus.ready <= ($urandom_range(0, 3) != 0);
      default: result_bus.ready <= ($urandom_range(0, 2) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    point_t want;
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      if (pending_points.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, actual x=%h y=%h plane=%0d last=%0d",
                 $time, result_bus.out_x, result_bus.out_y, result_bus.plane_id,
                 result_bus.last);
      end else begin
        want = pending_points.pop_front();
        compare_field("out_x", want.x, result_bus.out_x);
        compare_field("out_y", want.y, result_bus.out_y);
        compare_field("plane_id", coord_t'(want.plane), coord_t'(result_bus.plane_id));
        compare_field("last", coord_t'(want.last), coord_t'(result_bus.last));
      end
    end
  end

  initial begin
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = nhps_pkg::CFG_AXIS;
    cfg_data          = '0;
    pair_bus.valid    = 1'b0;
    pair_bus.cmd      = nhps_pkg::CMD_START;
    pair_bus.first_x  = '0;
    pair_bus.first_y  = '0;
    pair_bus.second_x = '0;
    pair_bus.second_y = '0;
    result_bus.ready  = 1'b0;
    axis_y    = 1'b0;
    cut_lim   = nhps_pkg::CUTOFF_RESET;
    fold_mod  = nhps_pkg::MODULUS_RESET;
    near_best = {1'b0, nhps_pkg::CUTOFF_RESET};
    keep_dx = '0;
    keep_dy = '0;
    keep_ax = '0;
    keep_ay = '0;
    keep_bx = '0;
    keep_by = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_missing_start();
    test_fold_on_y();
    test_saturation();
    test_cutoff_bounds();
    test_random_events();
    settle();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== nearest_hit_pair_search_unit.f =====
+incdir+hdl
hdl/nhps_pkg.sv
hdl/nhps_if.sv
hdl/nhps_mod_unit.sv
hdl/nearest_hit_pair_search_unit.sv
dv/nearest_hit_pair_search_unit_test.sv
